@@ rtl/stable_priority_mailbox_queue_assert.svh @@
// ----------------------------------------------------------------------------
// stable priority mailbox queue assertion macros
// shared property forms used by the checks in the top level
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_MAILBOX_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_MAILBOX_QUEUE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SPMQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spmq same-cycle check failed");

// next-cycle implication, disabled during reset
`define SPMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spmq next-cycle check failed");

`endif

@@ rtl/spmq_pkg.sv @@
// ----------------------------------------------------------------------------
// spmq_pkg
// types and codes shared by the stable priority mailbox queue
// ----------------------------------------------------------------------------
package spmq_pkg;

    localparam int HANDLE_W = 16;
    localparam int PRI_W    = 4;
    localparam int ENTRY_W  = 5;

    localparam logic [PRI_W-1:0] MAX_PRIORITY = 4'd9;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_READ   = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_code_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_BADPRI = 2'd2,
        STAT_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [PRI_W-1:0]    priority_req;
        logic [HANDLE_W-1:0] message_handle;
    } req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [HANDLE_W-1:0] head_handle;
        logic [PRI_W-1:0]    head_priority;
        logic [ENTRY_W-1:0]  entry_count;
    } rsp_t;

    // one stored slot
    typedef struct packed {
        logic [PRI_W-1:0]    pri;
        logic [HANDLE_W-1:0] handle;
    } slot_t;

endpackage

@@ rtl/stable_priority_mailbox_queue.sv @@
// ----------------------------------------------------------------------------
// stable_priority_mailbox_queue: ring of DEPTH slots kept sorted, highest first
// read, clear and rejected requests go straight to S_FIN; remove advances the base
//   (S_REM_ADV), then loads the new head (S_REM_LD) unless the last entry leaves;
//   insert walks from the tail; results wait on rsp_ready, one request at a time
// the insert walk reads one ring slot at a time through the single read port
// reset: async, queue empty, result register empty, no clearing pass
// ----------------------------------------------------------------------------
module stable_priority_mailbox_queue
    import spmq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

`include "stable_priority_mailbox_queue_assert.svh"

    localparam int IdxW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_INS_RD  = 7'b0000010,
        S_INS_CMP = 7'b0000100,
        S_INS_PUT = 7'b0001000,
        S_REM_ADV = 7'b0010000,
        S_REM_LD  = 7'b0100000,
        S_FIN     = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CntW-1:0]     cnt_reg, cnt_next;
    logic [IdxW-1:0]     base_reg, base_next;
    logic [IdxW-1:0]     idx_reg, idx_next;
    logic                rsp_valid_reg, rsp_valid_next;
    status_t             status_reg, status_next;
    slot_t               new_reg, new_next;
    slot_t               head_reg, head_next;
    rsp_t                rsp_reg, rsp_next;

    logic [IdxW-1:0]     offset;
    logic [IdxW-1:0]     phys;
    logic                ram_we;
    slot_t               ram_wdata;
    slot_t               ram_rdata;
    logic                accept;
    logic                out_free;
    logic [CntW+ENTRY_W-1:0] cnt_wide;
    logic                walking;
    logic                walk_ok;

    spmq_addr #(.DEPTH(DEPTH)) u_addr (
        .base   (base_reg),
        .offset (offset),
        .phys   (phys)
    );

    spmq_ram #(.DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (phys),
        .wdata (ram_wdata),
        .raddr (phys),
        .rdata (ram_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign cnt_wide  = (CntW+ENTRY_W)'(cnt_reg);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign walking   = (state_reg == S_INS_RD) || (state_reg == S_INS_CMP);
    assign walk_ok   = (idx_reg != '0) && ({1'b0, idx_reg} <= (IdxW+1)'(cnt_reg));

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        base_next      = base_reg;
        idx_next       = idx_reg;
        status_next    = status_reg;
        new_next       = new_reg;
        head_next      = head_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        offset         = idx_reg;
        ram_we         = 1'b0;
        ram_wdata      = new_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    new_next    = '{pri: req.priority_req, handle: req.message_handle};
                    status_next = STAT_OK;
                    state_next  = S_FIN;
                    unique case (req_code_t'(req.req_type))
                        REQ_INSERT:
                        begin
                            if (req.priority_req > MAX_PRIORITY)
                            begin
                                status_next = STAT_BADPRI;
                            end
                            else if (cnt_reg == CntW'(DEPTH))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                // walk starts at the tail
                                idx_next   = cnt_reg[IdxW-1:0];
                                state_next = (cnt_reg == '0) ? S_INS_PUT : S_INS_RD;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                idx_next   = IdxW'(1);
                                state_next = S_REM_ADV;
                            end
                        end
                        REQ_READ:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                offset     = idx_reg - IdxW'(1);
                state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                // lower priority ahead moves back one slot
                if (ram_rdata.pri < new_reg.pri)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                    idx_next   = idx_reg - IdxW'(1);
                    state_next = (idx_reg == IdxW'(1)) ? S_INS_PUT : S_INS_RD;
                end
                else
                begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT:
            begin
                ram_we    = 1'b1;
                ram_wdata = new_reg;
                if (idx_reg == '0)
                begin
                    head_next = new_reg;
                end
                cnt_next   = cnt_reg + CntW'(1);
                state_next = S_FIN;
            end
            S_REM_ADV:
            begin
                // phys points at the new head and is read this cycle
                base_next  = phys;
                cnt_next   = cnt_reg - CntW'(1);
                state_next = (cnt_reg == CntW'(1)) ? S_FIN : S_REM_LD;
            end
            S_REM_LD:
            begin
                head_next  = ram_rdata;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    rsp_next.status        = status_reg;
                    rsp_next.head_handle   = (cnt_reg != '0) ? head_reg.handle : '0;
                    rsp_next.head_priority = (cnt_reg != '0) ? head_reg.pri : '0;
                    rsp_next.entry_count   = cnt_wide[ENTRY_W-1:0];
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            base_reg      <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            base_reg      <= base_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        new_reg    <= new_next;
        head_reg   <= head_next;
        rsp_reg    <= rsp_next;
    end

    `SPMQ_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CntW'(DEPTH))
    `SPMQ_ASSERT_NOW(a_walk_in_range, clk, rst_n, walking, walk_ok)
    `SPMQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, !req_ready)

endmodule

@@ rtl/spmq_ram.sv @@
// ----------------------------------------------------------------------------
// spmq_ram
// slot store, one write port and one registered read port
// ----------------------------------------------------------------------------
module spmq_ram
    import spmq_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int IdxW = $clog2(DEPTH)
)
(
    input  logic            clk,
    input  logic            we,
    input  logic [IdxW-1:0] waddr,
    input  slot_t           wdata,
    input  logic [IdxW-1:0] raddr,
    output slot_t           rdata
);

    slot_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/spmq_addr.sv @@
// ----------------------------------------------------------------------------
// spmq_addr
// shared address unit: logical position to ring slot, wrapped at depth
// ----------------------------------------------------------------------------
module spmq_addr
    import spmq_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int IdxW = $clog2(DEPTH)
)
(
    input  logic [IdxW-1:0] base,
    input  logic [IdxW-1:0] offset,
    output logic [IdxW-1:0] phys
);

    logic [IdxW:0] sum;

    assign sum = {1'b0, base} + {1'b0, offset};

    always_comb
    begin
        if (sum >= (IdxW+1)'(DEPTH))
        begin
            phys = IdxW'(sum - (IdxW+1)'(DEPTH));
        end
        else
        begin
            phys = sum[IdxW-1:0];
        end
    end

endmodule
